// File: src/irhv_pkg.sv
package irhv_pkg;

  localparam int HDR_BYTES  = 16;
  localparam int CFG_DATA_W = 16;

  localparam logic [7:0] CTRL_LIMIT = 8'h20;
  localparam logic [7:0] CHR_SLASH  = 8'h2F;
  localparam logic [7:0] CHR_BSLASH = 8'h5C;
  localparam logic [7:0] CHR_DOT    = 8'h2E;

  // header byte offsets
  localparam logic [3:0] OFF_NAME_LO = 4'd8;
  localparam logic [3:0] OFF_NAME_HI = 4'd9;
  localparam logic [3:0] OFF_MIME_LO = 4'd10;
  localparam logic [3:0] OFF_MIME_HI = 4'd11;
  localparam logic [3:0] OFF_COMP    = 4'd12;

  typedef enum logic [1:0] {
    CFG_CODE_UNCOMP = 2'd0,
    CFG_CODE_COMP   = 2'd1,
    CFG_MAX_NAME    = 2'd2,
    CFG_MAX_MIME    = 2'd3
  } cfg_idx_t;

  // record state after the current word has been applied
  typedef struct packed {
    logic [63:0] payload_size;
    logic [15:0] name_size;
    logic [15:0] mime_size;
    logic [7:0]  compression;
    logic        saturated;
    logic        format_error;
    logic [1:0]  leading_dots;
  } hdr_t;

endpackage

// File: src/irhv_if.sv
interface irhv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source(output valid, data_byte, last_byte, input ready);
  modport sink(input valid, data_byte, last_byte, output ready);
endinterface

interface irhv_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [7:0]  compression;
  logic [15:0] name_length;
  logic [15:0] mime_length;
  logic [63:0] payload_length;

  modport source(output valid, status, compression, name_length, mime_length,
                 payload_length, input ready);
  modport sink(input valid, status, compression, name_length, mime_length,
               payload_length, output ready);
endinterface

// File: src/inner_record_header_validator_top.sv
// An accepted final word is held in the input register, its verdict in the
// output register on tx. Throughput: one word per cycle unless a final word
// waits on a pending result; the per-word checks and the final verdict are
// each a single registered pass, and the output register lets non-final
// words in while a result waits. Reset (rst, synchronous, active high)
// clears record state and the output valid, restores configuration defaults.
module inner_record_header_validator_top #(
  parameter int COUNT_BITS = 32  // record byte counter width, 17..64
) (
  input  logic                       clk,
  input  logic                       rst,
  irhv_in_if.sink                    rx,
  irhv_out_if.source                 tx,
  input  logic                       cfg_write,
  input  irhv_pkg::cfg_idx_t         cfg_index,
  input  logic [irhv_pkg::CFG_DATA_W-1:0] cfg_data
);
  import irhv_pkg::*;

  // input register -> tracker (per-byte header capture and name checks)
  // -> result (final verdict against config, output register)
  logic                  take;
  logic                  q_valid;
  logic [7:0]            q_byte;
  logic                  q_last;
  logic [COUNT_BITS-1:0] pos;
  hdr_t                  hdr_next;

  irhv_input_stage u_input (
    .clk     (clk),
    .rst     (rst),
    .rx      (rx),
    .take    (take),
    .q_valid (q_valid),
    .q_byte  (q_byte),
    .q_last  (q_last)
  );

  // Tracker state advances whenever the registered word is consumed; a final
  // word clears it for the next record in the same edge.
  irhv_tracker #(.COUNT_BITS(COUNT_BITS)) u_tracker (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .data_byte (q_byte),
    .last_byte (q_last),
    .pos       (pos),
    .hdr_next  (hdr_next)
  );

  // Non-final words never stall; a final word waits only for a free output slot.
  irhv_result #(.COUNT_BITS(COUNT_BITS)) u_result (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_last    (q_last),
    .pos       (pos),
    .hdr_next  (hdr_next),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .take      (take),
    .tx        (tx)
  );

endmodule

// File: src/irhv_input_stage.sv
module irhv_input_stage (
  input  logic       clk,
  input  logic       rst,
  irhv_in_if.sink    rx,
  input  logic       take,
  output logic       q_valid,
  output logic [7:0] q_byte,
  output logic       q_last
);
  import irhv_pkg::*;

  assign rx.ready = !q_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (rx.ready) begin
      q_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      q_byte <= rx.data_byte;
      q_last <= rx.last_byte;
    end
  end

endmodule

// File: src/irhv_tracker.sv
module irhv_tracker #(
  parameter int COUNT_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  take,
  input  logic [7:0]            data_byte,
  input  logic                  last_byte,
  output logic [COUNT_BITS-1:0] pos,
  output irhv_pkg::hdr_t        hdr_next
);
  import irhv_pkg::*;

  logic [COUNT_BITS-1:0] byte_count;
  logic                  count_saturated;
  logic [63:0]           payload_size_reg;
  logic [15:0]           name_size_reg;
  logic [15:0]           mime_size_reg;
  logic [7:0]            compression_reg;
  logic                  format_error;
  logic [1:0]            leading_dots;

  logic [COUNT_BITS-1:0] name_off;
  logic                  in_header;
  logic                  in_name;
  logic                  bad_char;

  assign pos       = byte_count;
  assign in_header = (byte_count[COUNT_BITS-1:4] == '0);
  assign name_off  = byte_count - COUNT_BITS'(HDR_BYTES);
  assign in_name   = !in_header && (name_off < COUNT_BITS'(name_size_reg));
  assign bad_char  = (data_byte == CHR_SLASH) || (data_byte == CHR_BSLASH) ||
                     (data_byte < CTRL_LIMIT);

  always_comb begin
    hdr_next.payload_size = payload_size_reg;
    hdr_next.name_size    = name_size_reg;
    hdr_next.mime_size    = mime_size_reg;
    hdr_next.compression  = compression_reg;
    hdr_next.format_error = format_error;
    hdr_next.leading_dots = leading_dots;
    hdr_next.saturated    = count_saturated || (&byte_count);
    if (!count_saturated) begin
      if (in_header) begin
        if (!byte_count[3]) begin
          hdr_next.payload_size[{byte_count[2:0], 3'b000} +: 8] = data_byte;
        end else begin
          case (byte_count[3:0])
            OFF_NAME_LO: hdr_next.name_size[7:0]  = data_byte;
            OFF_NAME_HI: hdr_next.name_size[15:8] = data_byte;
            OFF_MIME_LO: hdr_next.mime_size[7:0]  = data_byte;
            OFF_MIME_HI: hdr_next.mime_size[15:8] = data_byte;
            OFF_COMP:    hdr_next.compression     = data_byte;
            default: begin
              // reserved bytes must be zero
              if (data_byte != 8'h00) hdr_next.format_error = 1'b1;
            end
          endcase
        end
      end else if (in_name) begin
        if (bad_char) hdr_next.format_error = 1'b1;
        if ((data_byte == CHR_DOT) && (name_off == COUNT_BITS'(leading_dots)) &&
            !leading_dots[1]) begin
          hdr_next.leading_dots = leading_dots + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (take && last_byte)) begin
      byte_count       <= '0;
      count_saturated  <= 1'b0;
      payload_size_reg <= '0;
      name_size_reg    <= '0;
      mime_size_reg    <= '0;
      compression_reg  <= '0;
      format_error     <= 1'b0;
      leading_dots     <= '0;
    end else if (take) begin
      if (!(&byte_count)) byte_count <= byte_count + 1'b1;
      count_saturated  <= hdr_next.saturated;
      payload_size_reg <= hdr_next.payload_size;
      name_size_reg    <= hdr_next.name_size;
      mime_size_reg    <= hdr_next.mime_size;
      compression_reg  <= hdr_next.compression;
      format_error     <= hdr_next.format_error;
      leading_dots     <= hdr_next.leading_dots;
    end
  end

endmodule

// File: src/irhv_result.sv
module irhv_result #(
  parameter int COUNT_BITS = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  input  logic                       q_last,
  input  logic [COUNT_BITS-1:0]      pos,
  input  irhv_pkg::hdr_t             hdr_next,
  input  logic                       cfg_write,
  input  irhv_pkg::cfg_idx_t         cfg_index,
  input  logic [irhv_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                       take,
  irhv_out_if.source                 tx
);
  import irhv_pkg::*;

  logic [7:0]  code_uncompressed;
  logic [7:0]  code_compressed;
  logic [15:0] max_name_length;
  logic [15:0] max_mime_length;

  logic        err;
  logic        bad_comp;
  logic        bad_limit;
  logic        bad_dots;
  logic        bad_size;
  logic [64:0] claimed_len;
  logic [64:0] body_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      code_uncompressed <= 8'd0;
      code_compressed   <= 8'd1;
      max_name_length   <= 16'd255;
      max_mime_length   <= 16'd255;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_CODE_UNCOMP: code_uncompressed <= cfg_data[7:0];
        CFG_CODE_COMP:   code_compressed   <= cfg_data[7:0];
        CFG_MAX_NAME:    max_name_length   <= cfg_data;
        CFG_MAX_MIME:    max_mime_length   <= cfg_data;
      endcase
    end
  end

  assign take = q_valid && (!q_last || !tx.valid || tx.ready);

  assign bad_comp  = (hdr_next.compression != code_uncompressed) &&
                     (hdr_next.compression != code_compressed);
  assign bad_limit = (hdr_next.name_size > max_name_length) ||
                     (hdr_next.mime_size > max_mime_length);
  assign bad_dots  = ((hdr_next.name_size == 16'd1) &&
                      (hdr_next.leading_dots != 2'd0)) ||
                     ((hdr_next.name_size == 16'd2) &&
                      (hdr_next.leading_dots == 2'd2));
  // record length minus header is pos + 1 - 16
  assign claimed_len = {1'b0, hdr_next.payload_size} + 65'(hdr_next.name_size) +
                       65'(hdr_next.mime_size);
  assign body_len    = 65'(pos - COUNT_BITS'(HDR_BYTES - 1));
  assign bad_size    = (claimed_len != body_len);

  assign err = hdr_next.format_error || hdr_next.saturated ||
               (pos < COUNT_BITS'(HDR_BYTES - 1)) ||
               bad_comp || bad_limit || bad_dots || bad_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      tx.valid <= 1'b0;
    end else if (take && q_last) begin
      tx.valid <= 1'b1;
    end else if (tx.ready) begin
      tx.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && q_last) begin
      tx.status         <= err;
      tx.compression    <= err ? '0 : hdr_next.compression;
      tx.name_length    <= err ? '0 : hdr_next.name_size;
      tx.mime_length    <= err ? '0 : hdr_next.mime_size;
      tx.payload_length <= err ? '0 : hdr_next.payload_size;
    end
  end

endmodule

// File: sim/inner_record_header_validator_top_tb.sv
module inner_record_header_validator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import irhv_pkg::*;

  // Narrowest legal counter.
  localparam int REC_CNT_W = 17;
  localparam int CYCLE_LIMIT = 200_000;

  // how the name bytes of a generated record look
  typedef enum logic [2:0] {
    NM_RAND,      // legal printable bytes
    NM_DOTS,      // all '.'
    NM_DOT_THEN,  // '.' then legal bytes
    NM_SPACE,     // all 0x20, lowest legal byte
    NM_SLASH,     // last name byte '/'
    NM_BSLASH,    // last name byte '\'
    NM_CTRL,      // last name byte below 0x20
    NM_JUNK       // any byte at all
  } name_pat_t;

  // one record to send: header fields, name look, total length in bytes,
  // and an optional hand-written verdict (status, all fields zero)
  typedef struct packed {
    logic [63:0] plen;
    logic [15:0] nlen;
    logic [15:0] mlen;
    logic [7:0]  comp;
    logic [23:0] rsv;
    name_pat_t   pat;
    int          len;
    logic        typed;
    logic        st;
  } rec_t;

  typedef struct packed {
    logic        status;
    logic [7:0]  comp;
    logic [15:0] nlen;
    logic [15:0] mlen;
    logic [63:0] plen;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write;
  cfg_idx_t cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  irhv_in_if  rx_if();
  irhv_out_if tx_if();

  inner_record_header_validator_top #(.COUNT_BITS(REC_CNT_W)) DUT (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx_if),
    .tx        (tx_if),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // register copies, reset values
  logic [7:0]  cfg_code_u   = 8'd0;
  logic [7:0]  cfg_code_c   = 8'd1;
  logic [15:0] cfg_name_max = 16'd255;
  logic [15:0] cfg_mime_max = 16'd255;

  // record tracking state
  logic [REC_CNT_W-1:0] seen_cnt = '0;
  logic                 seen_sat = 1'b0;
  logic [63:0]          hdr_plen = '0;
  logic [15:0]          hdr_nlen = '0;
  logic [15:0]          hdr_mlen = '0;
  logic [7:0]           hdr_comp = '0;
  logic                 name_bad = 1'b0;
  logic [1:0]           dot_run  = '0;

  verdict_t verdict_q[$];   // verdicts of accepted final words, oldest first
  int       fails = 0;
  int       cycles = 0;
  int       send_idle = 0;  // percent of cycles the sender holds back
  int       recv_stall = 0; // percent of cycles the receiver stalls

  // Directed records under reset config (codes 0/1, limits 255/255).
  rec_t plan [23] = '{
    // all-zero header, empty body: valid, every field zero
    '{64'd0, 16'd0, 16'd0, 8'd0, 24'd0, NM_RAND, 16, 1'b1, 1'b0},
    // small valid record, compressed code
    '{64'd4, 16'd3, 16'd2, 8'd1, 24'd0, NM_RAND, 25, 1'b0, 1'b0},
    // unknown compression codes
    '{64'd0, 16'd0, 16'd0, 8'd2, 24'd0, NM_RAND, 16, 1'b1, 1'b1},
    '{64'd0, 16'd0, 16'd0, 8'hFF, 24'd0, NM_RAND, 16, 1'b1, 1'b1},
    // nonzero reserved, last and first reserved byte
    '{64'd0, 16'd0, 16'd0, 8'd0, 24'hFF0000, NM_RAND, 16, 1'b1, 1'b1},
    '{64'd0, 16'd0, 16'd0, 8'd0, 24'h000001, NM_RAND, 16, 1'b1, 1'b1},
    // "." and ".." are refused, "..." and ".x" are not
    '{64'd0, 16'd1, 16'd0, 8'd0, 24'd0, NM_DOTS, 17, 1'b1, 1'b1},
    '{64'd0, 16'd2, 16'd0, 8'd0, 24'd0, NM_DOTS, 18, 1'b1, 1'b1},
    '{64'd0, 16'd3, 16'd0, 8'd0, 24'd0, NM_DOTS, 19, 1'b0, 1'b0},
    '{64'd0, 16'd2, 16'd0, 8'd1, 24'd0, NM_DOT_THEN, 18, 1'b0, 1'b0},
    // forbidden name bytes
    '{64'd0, 16'd4, 16'd0, 8'd0, 24'd0, NM_SLASH, 20, 1'b1, 1'b1},
    '{64'd0, 16'd4, 16'd0, 8'd0, 24'd0, NM_BSLASH, 20, 1'b1, 1'b1},
    '{64'd0, 16'd4, 16'd0, 8'd0, 24'd0, NM_CTRL, 20, 1'b1, 1'b1},
    '{64'd1, 16'd4, 16'd1, 8'd0, 24'd0, NM_SPACE, 22, 1'b0, 1'b0},
    // name length at the limit, one past it
    '{64'd2, 16'd255, 16'd0, 8'd1, 24'd0, NM_RAND, 273, 1'b0, 1'b0},
    '{64'd0, 16'd256, 16'd0, 8'd0, 24'd0, NM_RAND, 272, 1'b1, 1'b1},
    // short records
    '{64'd0, 16'd0, 16'd0, 8'd0, 24'd0, NM_RAND, 15, 1'b1, 1'b1},
    '{64'd0, 16'd0, 16'd0, 8'd0, 24'd0, NM_RAND, 1, 1'b1, 1'b1},
    // total length one short, one long
    '{64'd5, 16'd0, 16'd0, 8'd0, 24'd0, NM_RAND, 20, 1'b1, 1'b1},
    '{64'd5, 16'd0, 16'd0, 8'd0, 24'd0, NM_RAND, 22, 1'b1, 1'b1},
    // name + mime longer than what follows the header
    '{64'd0, 16'd3, 16'd3, 8'd0, 24'd0, NM_RAND, 20, 1'b1, 1'b1},
    // every header bit set
    '{64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 24'hFFFFFF, NM_JUNK, 24,
      1'b1, 1'b1},
    // state must be clean again after an error record
    '{64'd3, 16'd1, 16'd1, 8'd1, 24'd0, NM_RAND, 21, 1'b0, 1'b0}
  };

  task automatic flag(input string what, input logic [63:0] got, input logic [63:0] want);
    fails++;
    $display("[%0t] %s mismatch: got %0h expected %0h", $realtime, what, got, want);
  endtask

  // Predictor: applies one accepted word; on the final word gives the verdict
  // and clears the record state.
  task automatic track_byte(input logic [7:0] b, input logic fin,
                            output bit have, output verdict_t v);
    longint unsigned pos, k, in_len, rest, meta;
    bit err;
    pos = seen_cnt;
    have = 1'b0;
    v = '0;
    if (!seen_sat) begin
      if (pos < 8)
        hdr_plen = hdr_plen | (64'(b) << (8 * pos));
      else if (pos == 8)
        hdr_nlen[7:0] = b;
      else if (pos == 9)
        hdr_nlen[15:8] = b;
      else if (pos == 10)
        hdr_mlen[7:0] = b;
      else if (pos == 11)
        hdr_mlen[15:8] = b;
      else if (pos == 12)
        hdr_comp = b;
      else if (pos < HDR_BYTES) begin
        if (b != 8'd0) name_bad = 1'b1;
      end else if (pos - HDR_BYTES < hdr_nlen) begin
        k = pos - HDR_BYTES;
        if (b == CHR_SLASH || b == CHR_BSLASH || b < CTRL_LIMIT) name_bad = 1'b1;
        if (b == CHR_DOT && k == dot_run && k < 2) dot_run = dot_run + 2'd1;
      end
    end
    // counter holds at all ones; any further byte saturates
    if (&seen_cnt)
      seen_sat = 1'b1;
    else
      seen_cnt = seen_cnt + 1'b1;

    if (fin) begin
      err = name_bad || seen_sat;
      if (!err) begin
        in_len = pos + 1;
        if (in_len < HDR_BYTES) begin
          err = 1'b1;
        end else begin
          if (hdr_comp != cfg_code_u && hdr_comp != cfg_code_c) err = 1'b1;
          if (hdr_nlen > cfg_name_max || hdr_mlen > cfg_mime_max) err = 1'b1;
          if ((hdr_nlen == 16'd1 && dot_run >= 2'd1) ||
              (hdr_nlen == 16'd2 && dot_run == 2'd2)) err = 1'b1;
          rest = in_len - HDR_BYTES;
          meta = 64'(hdr_nlen) + 64'(hdr_mlen);
          if (meta > rest || hdr_plen != rest - meta) err = 1'b1;
        end
      end
      have = 1'b1;
      v.status = err;
      if (!err) begin
        v.comp = hdr_comp;
        v.nlen = hdr_nlen;
        v.mlen = hdr_mlen;
        v.plen = hdr_plen;
      end
      seen_cnt = '0;
      seen_sat = 1'b0;
      hdr_plen = '0;
      hdr_nlen = '0;
      hdr_mlen = '0;
      hdr_comp = '0;
      name_bad = 1'b0;
      dot_run  = '0;
    end
  endtask

  function automatic logic [7:0] legal_name_byte();
    logic [7:0] b;
    do
      b = 8'($urandom_range(8'hFF, CTRL_LIMIT));
    while (b == CHR_SLASH || b == CHR_BSLASH);
    return b;
  endfunction

  // byte i of record r
  function automatic logic [7:0] rec_byte(input rec_t r, input int i);
    int k;
    int nl;
    k = i - HDR_BYTES;
    nl = int'(r.nlen);
    if (i < 8) return r.plen[8*i +: 8];
    if (i == 8) return r.nlen[7:0];
    if (i == 9) return r.nlen[15:8];
    if (i == 10) return r.mlen[7:0];
    if (i == 11) return r.mlen[15:8];
    if (i == 12) return r.comp;
    if (i < HDR_BYTES) return r.rsv[8*(i-13) +: 8];
    if (k < nl) begin
      case (r.pat)
        NM_DOTS:     return CHR_DOT;
        NM_DOT_THEN: return (k == 0) ? CHR_DOT : legal_name_byte();
        NM_SPACE:    return CTRL_LIMIT;
        NM_SLASH:    return (k == nl - 1) ? CHR_SLASH : legal_name_byte();
        NM_BSLASH:   return (k == nl - 1) ? CHR_BSLASH : legal_name_byte();
        NM_CTRL:     return (k == nl - 1) ? 8'($urandom_range(31)) : legal_name_byte();
        NM_JUNK:     return 8'($urandom_range(255));
        default:     return legal_name_byte();
      endcase
    end
    return 8'($urandom_range(255));
  endfunction

  // One word on rx. Valid stays high from word to word unless an idle
  // cycle is drawn, so it never drops and rises in one step.
  task automatic send_word(input logic [7:0] b, input logic fin,
                           output bit have, output verdict_t v);
    while ($urandom_range(99) < send_idle) begin
      rx_if.valid <= 1'b0;
      @(posedge clk);
    end
    rx_if.valid     <= 1'b1;
    rx_if.data_byte <= b;
    rx_if.last_byte <= fin;
    @(posedge clk);
    while (!rx_if.ready) @(posedge clk);
    track_byte(b, fin, have, v);
  endtask

  task automatic send_record(input rec_t r);
    bit have;
    verdict_t v;
    for (int i = 0; i < r.len; i++) begin
      send_word(rec_byte(r, i), i == r.len - 1, have, v);
      if (have) begin
        if (r.typed) begin
          v = '0;
          v.status = r.st;
        end
        verdict_q.push_back(v);
      end
    end
  endtask

  // Mostly well-formed records within the current limits; about a quarter
  // carry one fault.
  task automatic pick_record(output rec_t r);
    int nmax, mmax, p, fault, sel;
    nmax = (cfg_name_max < 6) ? int'(cfg_name_max) : 6;
    if ($urandom_range(19) == 0) nmax = (cfg_name_max < 40) ? int'(cfg_name_max) : 40;
    mmax = (cfg_mime_max < 6) ? int'(cfg_mime_max) : 6;
    p = $urandom_range(10);
    r = '0;
    r.plen = 64'(p);
    r.nlen = 16'($urandom_range(nmax));
    r.mlen = 16'($urandom_range(mmax));
    r.comp = $urandom_range(1) ? cfg_code_u : cfg_code_c;
    sel = $urandom_range(99);
    r.pat = (sel < 12) ? NM_DOTS : (sel < 22) ? NM_DOT_THEN : NM_RAND;
    fault = ($urandom_range(99) < 28) ? $urandom_range(7) : -1;

    // header faults
    case (fault)
      0: r.comp = 8'($urandom);
      1: begin
        sel = $urandom_range(2);
        r.rsv[8*sel +: 8] = 8'($urandom_range(255, 1));
      end
      2: begin
        if (r.nlen == 0) r.nlen = 16'd1;
        r.pat = name_pat_t'(int'(NM_SLASH) + $urandom_range(3));
      end
      5: begin
        if (cfg_name_max < 16'd65530)
          r.nlen = cfg_name_max + 16'($urandom_range(3, 1));
        else
          r.mlen = cfg_mime_max + 16'($urandom_range(3, 1));
      end
      default: ;
    endcase
    r.len = HDR_BYTES + int'(r.nlen) + int'(r.mlen) + p;

    // length faults
    case (fault)
      3: r.len = $urandom_range(1) ? r.len + 1 : r.len - 1;
      4: r.len = $urandom_range(15, 1);
      6: begin
        r.plen = {$urandom, $urandom};
        r.nlen = 16'($urandom);
        r.mlen = 16'($urandom);
        r.comp = 8'($urandom);
        r.rsv  = 24'($urandom);
        r.pat  = NM_JUNK;
        r.len  = $urandom_range(40, 1);
      end
      7: r.plen = r.plen + 64'($urandom_range(5, 1));
      default: ;
    endcase
  endtask

  task automatic run_random(input int byte_goal, input int rec_goal);
    rec_t r;
    int nbytes;
    int nrec;
    nbytes = 0;
    nrec = 0;
    while (nbytes < byte_goal || nrec < rec_goal) begin
      pick_record(r);
      send_record(r);
      nbytes += r.len;
      nrec++;
    end
  endtask

  // drop valid, wait for every pending verdict, then a few cycles more
  task automatic settle();
    rx_if.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // one register write per cycle; caller lowers cfg_write after the last
  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] v);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    case (idx)
      CFG_CODE_UNCOMP: cfg_code_u   = v[7:0];
      CFG_CODE_COMP:   cfg_code_c   = v[7:0];
      CFG_MAX_NAME:    cfg_name_max = v;
      CFG_MAX_MIME:    cfg_mime_max = v;
      default: ;
    endcase
  endtask

  // receiver back-pressure
  always @(posedge clk) tx_if.ready <= ($urandom_range(99) >= recv_stall);

  // result check against the oldest pending verdict
  always @(posedge clk) begin : check_result
    verdict_t want;
    if (!rst && tx_if.valid && tx_if.ready) begin
      if (verdict_q.size() == 0) begin
        flag("unexpected result word, payload_length", tx_if.payload_length, '0);
      end else begin
        want = verdict_q.pop_front();
        if (tx_if.status !== want.status)
          flag("status", 64'(tx_if.status), 64'(want.status));
        if (tx_if.compression !== want.comp)
          flag("compression", 64'(tx_if.compression), 64'(want.comp));
        if (tx_if.name_length !== want.nlen)
          flag("name_length", 64'(tx_if.name_length), 64'(want.nlen));
        if (tx_if.mime_length !== want.mlen)
          flag("mime_length", 64'(tx_if.mime_length), 64'(want.mlen));
        if (tx_if.payload_length !== want.plen)
          flag("payload_length", tx_if.payload_length, want.plen);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[inner_record_header_validator_top] ERROR");
      $finish;
    end
  end

  initial begin
    rx_if.valid     = 1'b0;
    rx_if.data_byte = 8'd0;
    rx_if.last_byte = 1'b0;
    cfg_write       = 1'b0;
    cfg_index       = CFG_CODE_UNCOMP;
    cfg_data        = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset config, no idling: directed records, then random
    foreach (plan[i]) send_record(plan[i]);
    run_random(80, 4);
    settle();

    // swapped extreme codes, no names allowed; sender idles
    write_reg(CFG_CODE_UNCOMP, {8'($urandom), 8'hFF});
    write_reg(CFG_CODE_COMP, {8'($urandom), 8'h00});
    write_reg(CFG_MAX_NAME, 16'd0);
    write_reg(CFG_MAX_MIME, 16'hFFFF);
    cfg_write <= 1'b0;
    send_idle = 55;
    recv_stall = 0;
    run_random(80, 4);
    settle();

    // random codes, widest name limit, no mime; receiver stalls
    write_reg(CFG_CODE_UNCOMP, 16'($urandom));
    write_reg(CFG_CODE_COMP, 16'($urandom));
    write_reg(CFG_MAX_NAME, 16'hFFFF);
    write_reg(CFG_MAX_MIME, 16'd0);
    cfg_write <= 1'b0;
    send_idle = 0;
    recv_stall = 55;
    run_random(80, 4);
    settle();

    // random codes, tight random limits; light idling on both sides
    write_reg(CFG_CODE_UNCOMP, 16'($urandom));
    write_reg(CFG_CODE_COMP, 16'($urandom));
    write_reg(CFG_MAX_NAME, 16'($urandom_range(8)));
    write_reg(CFG_MAX_MIME, 16'($urandom_range(8)));
    cfg_write <= 1'b0;
    send_idle = 12;
    recv_stall = 12;
    run_random(80, 4);
    settle();

    if (fails == 0 && verdict_q.size() == 0)
      $display("[inner_record_header_validator_top] OK");
    else
      $display("[inner_record_header_validator_top] ERROR");
    $finish;
  end

endmodule
